FILE: rtl/core/fingertip_shape_alpha_pixel_macros.svh
// ----------------------------------------------------------------------------
// Fingertip silhouette alpha: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FINGERTIP_SHAPE_ALPHA_PIXEL_MACROS_SVH
`define FINGERTIP_SHAPE_ALPHA_PIXEL_MACROS_SVH

// condition holds at every edge
`define FTSA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define FTSA_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define FTSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/ftsa_pkg.sv
// ----------------------------------------------------------------------------
// Fingertip silhouette alpha: package
// Widths, register indexes, reset values and item kinds.
// ----------------------------------------------------------------------------
`default_nettype none

package ftsa_pkg;

  localparam int EXT_W               = 9;
  localparam int COORD_BITS_DEF      = 10;
  localparam int ALPHA_FRAC_BITS_DEF = 8;
  localparam int SQRT_GUARD          = 12;
  localparam int CFG_IDX_W           = 3;

  localparam int FEATHER_NUM = 25;
  localparam int NEAR_LHS    = 625;
  localparam int NEAR_RHS    = 529;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIDDLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 3'd4;

  localparam logic [EXT_W-1:0] LEFT_RST   = 9'd100;
  localparam logic [EXT_W-1:0] RIGHT_RST  = 9'd100;
  localparam logic [EXT_W-1:0] TOP_RST    = 9'd120;
  localparam logic [EXT_W-1:0] MIDDLE_RST = 9'd140;
  localparam logic [EXT_W-1:0] BOTTOM_RST = 9'd100;

  typedef enum logic [2:0] {
    KIND_ZERO = 3'd0,
    KIND_ONE  = 3'd1,
    KIND_BAND = 3'd2,
    KIND_ELL  = 3'd3,
    KIND_DIV  = 3'd4
  } kind_t;

endpackage

`default_nettype wire

FILE: rtl/core/fingertip_shape_alpha_pixel.sv
// ----------------------------------------------------------------------------
// Fingertip silhouette alpha
// Coverage alpha and dark flag of a feathered fingertip outline, per pixel.
// ----------------------------------------------------------------------------
// One coordinate word is taken every cycle unless the output is stalled, and one
// result word leaves for each, in order. Each word passes the 30-stage root
// extraction and the ALPHA_FRAC_BITS+1 stage restoring divider; a stall on the
// output holds the whole pipeline. The user must write extents only while no
// word is in flight; the block itself does not enforce this.
`default_nettype none

module fingertip_shape_alpha_pixel #(
  parameter int COORD_BITS      = ftsa_pkg::COORD_BITS_DEF,
  parameter int ALPHA_FRAC_BITS = ftsa_pkg::ALPHA_FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [ftsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ftsa_pkg::EXT_W-1:0]       cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [COORD_BITS-1:0]            x_pos,
  input  wire logic [COORD_BITS-1:0]            y_pos,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [ALPHA_FRAC_BITS:0]              alpha,
  output logic                                  dark
);

  localparam int EW    = ftsa_pkg::EXT_W;
  localparam int GD    = ftsa_pkg::SQRT_GUARD;
  localparam int CW    = ((COORD_BITS > EW + 2) ? COORD_BITS : EW + 2) + 1;
  localparam int SQ_W  = 2 * EW;
  localparam int PR_W  = 4 * EW;
  localparam int BN_W  = EW + 5;
  localparam int RT    = SQ_W + GD;
  localparam int PW    = RT;
  localparam int NW    = PW + 5 + ALPHA_FRAC_BITS;
  localparam int DW    = PW + 1;
  localparam int RW    = NW + 1;
  localparam int QB    = ALPHA_FRAC_BITS + 1;
  localparam int ONE_W = ALPHA_FRAC_BITS + 1;
  localparam logic [ONE_W-1:0] ONE  = ONE_W'(1) << ALPHA_FRAC_BITS;
  localparam logic [ONE_W-1:0] HALF = ONE_W'(1) << (ALPHA_FRAC_BITS - 1);

  typedef struct packed {
    ftsa_pkg::kind_t kind;
    logic [EW-1:0]   adx;
    logic [EW-1:0]   ady;
    logic [EW-1:0]   ax;
    logic [EW-1:0]   ay;
    logic [EW-1:0]   gap;
    logic [EW-1:0]   m;
  } s1_t;

  typedef struct packed {
    ftsa_pkg::kind_t kind;
    logic [SQ_W-1:0] adx2;
    logic [SQ_W-1:0] ady2;
    logic [SQ_W-1:0] ax2;
    logic [SQ_W-1:0] ay2;
    logic [SQ_W-1:0] axy;
    logic [BN_W-1:0] bnum;
    logic [EW:0]     bden;
  } s2_t;

  typedef struct packed {
    ftsa_pkg::kind_t kind;
    logic [PR_W-1:0] t1;
    logic [PR_W-1:0] t2;
    logic [PR_W-1:0] dd;
    logic [SQ_W-1:0] axy;
    logic [BN_W-1:0] bnum;
    logic [EW:0]     bden;
  } s3_t;

  typedef struct packed {
    ftsa_pkg::kind_t kind;
    logic [PR_W:0]   s;
    logic [PR_W-1:0] dd;
    logic [SQ_W-1:0] axy;
    logic [BN_W-1:0] bnum;
    logic [EW:0]     bden;
  } s4_t;

  typedef struct packed {
    ftsa_pkg::kind_t  kind;
    logic [PR_W:0]    s;
    logic [PR_W-1:0]  dd;
    logic [PR_W+10:0] s625;
    logic [PR_W+9:0]  d529;
    logic [SQ_W-1:0]  axy;
    logic [BN_W-1:0]  bnum;
    logic [EW:0]      bden;
  } s5_t;

  typedef struct packed {
    ftsa_pkg::kind_t kind;
    logic [RT+3:0]   rem;
    logic [RT-1:0]   root;
    logic [2*RT-1:0] rad;
    logic [SQ_W-1:0] axy;
    logic [BN_W-1:0] bnum;
    logic [EW:0]     bden;
  } sq_t;

  typedef struct packed {
    ftsa_pkg::kind_t kind;
    logic [RW-1:0]   rem;
    logic [DW-1:0]   den;
    logic [QB-1:0]   q;
  } dv_t;

  logic [EW-1:0] left_extent;
  logic [EW-1:0] right_extent;
  logic [EW-1:0] top_extent;
  logic [EW-1:0] middle_extent;
  logic [EW-1:0] bottom_extent;

  logic          en;
  logic [4:0]    v_front;
  logic [RT:0]   v_sq;
  logic [QB:0]   v_dv;

  s1_t s1, s1_next;
  s2_t s2, s2_next;
  s3_t s3, s3_next;
  s4_t s4, s4_next;
  s5_t s5, s5_next;
  sq_t sq_next;
  sq_t sq [RT+1];
  dv_t dv_next;
  dv_t dv [QB+1];
  logic [ONE_W-1:0] alpha_next;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_extent   <= ftsa_pkg::LEFT_RST;
      right_extent  <= ftsa_pkg::RIGHT_RST;
      top_extent    <= ftsa_pkg::TOP_RST;
      middle_extent <= ftsa_pkg::MIDDLE_RST;
      bottom_extent <= ftsa_pkg::BOTTOM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ftsa_pkg::REG_LEFT:   left_extent   <= cfg_data;
        ftsa_pkg::REG_RIGHT:  right_extent  <= cfg_data;
        ftsa_pkg::REG_TOP:    top_extent    <= cfg_data;
        ftsa_pkg::REG_MIDDLE: middle_extent <= cfg_data;
        ftsa_pkg::REG_BOTTOM: bottom_extent <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: geometry
  always_comb begin
    logic [CW-1:0] xe, ye, le, re, te, w, h, band_end, adx_f, ady_f, rd, gap_f;
    logic          left_side, cap, base;
    xe        = CW'(x_pos);
    ye        = CW'(y_pos);
    le        = CW'(left_extent);
    re        = CW'(right_extent);
    te        = CW'(top_extent);
    w         = le + re;
    band_end  = te + CW'(middle_extent);
    h         = band_end + CW'(bottom_extent);
    left_side = xe <= le;
    adx_f     = left_side ? le - xe : xe - le;
    cap       = ye < te;
    base      = ye > band_end;
    ady_f     = cap ? te - ye : ye - band_end;
    rd        = w - CW'(1) - xe;
    gap_f     = (xe < rd) ? xe : rd;
    s1_next.adx  = adx_f[EW-1:0];
    s1_next.ady  = ady_f[EW-1:0];
    s1_next.ax   = left_side ? left_extent : right_extent;
    s1_next.ay   = cap ? top_extent : bottom_extent;
    s1_next.gap  = gap_f[EW-1:0];
    s1_next.m    = (left_extent < right_extent) ? left_extent : right_extent;
    if (!(xe < w && ye < h)) begin
      s1_next.kind = ftsa_pkg::KIND_ZERO;
    end else if (!cap && !base) begin
      s1_next.kind = (s1_next.m == '0) ? ftsa_pkg::KIND_ONE : ftsa_pkg::KIND_BAND;
    end else if (s1_next.ax == '0 || s1_next.ay == '0) begin
      s1_next.kind = ftsa_pkg::KIND_ZERO;
    end else begin
      s1_next.kind = ftsa_pkg::KIND_ELL;
    end
  end

  // stage 2: squares
  always_comb begin
    s2_next.adx2 = SQ_W'(s1.adx) * SQ_W'(s1.adx);
    s2_next.ady2 = SQ_W'(s1.ady) * SQ_W'(s1.ady);
    s2_next.ax2  = SQ_W'(s1.ax) * SQ_W'(s1.ax);
    s2_next.ay2  = SQ_W'(s1.ay) * SQ_W'(s1.ay);
    s2_next.axy  = SQ_W'(s1.ax) * SQ_W'(s1.ay);
    s2_next.bnum = BN_W'(s1.gap) * BN_W'(ftsa_pkg::FEATHER_NUM);
    s2_next.bden = {s1.m, 1'b0};
    s2_next.kind = s1.kind;
    if (s1.kind == ftsa_pkg::KIND_BAND && s2_next.bnum >= BN_W'(s2_next.bden)) begin
      s2_next.kind = ftsa_pkg::KIND_ONE;
    end
  end

  // stage 3: cross products
  always_comb begin
    s3_next.kind = s2.kind;
    s3_next.t1   = PR_W'(s2.adx2) * PR_W'(s2.ay2);
    s3_next.t2   = PR_W'(s2.ady2) * PR_W'(s2.ax2);
    s3_next.dd   = PR_W'(s2.ax2) * PR_W'(s2.ay2);
    s3_next.axy  = s2.axy;
    s3_next.bnum = s2.bnum;
    s3_next.bden = s2.bden;
  end

  // stage 4: sum
  always_comb begin
    s4_next.kind = s3.kind;
    s4_next.s    = (PR_W + 1)'(s3.t1) + (PR_W + 1)'(s3.t2);
    s4_next.dd   = s3.dd;
    s4_next.axy  = s3.axy;
    s4_next.bnum = s3.bnum;
    s4_next.bden = s3.bden;
  end

  // stage 5: inner feather threshold products
  always_comb begin
    s5_next.kind = s4.kind;
    s5_next.s    = s4.s;
    s5_next.dd   = s4.dd;
    s5_next.s625 = (PR_W + 11)'(s4.s) * (PR_W + 11)'(ftsa_pkg::NEAR_LHS);
    s5_next.d529 = (PR_W + 10)'(s4.dd) * (PR_W + 10)'(ftsa_pkg::NEAR_RHS);
    s5_next.axy  = s4.axy;
    s5_next.bnum = s4.bnum;
    s5_next.bden = s4.bden;
  end

  // stage 6: classify the ellipse pixel, load the root extraction
  always_comb begin
    sq_next.kind = s5.kind;
    if (s5.kind == ftsa_pkg::KIND_ELL) begin
      if (s5.s625 < (PR_W + 11)'(s5.d529)) begin
        sq_next.kind = ftsa_pkg::KIND_ONE;
      end else if (s5.s >= (PR_W + 1)'(s5.dd)) begin
        sq_next.kind = ftsa_pkg::KIND_ZERO;
      end
    end
    sq_next.rem  = '0;
    sq_next.root = '0;
    sq_next.rad  = {s5.s[PR_W-1:0], {(2 * GD){1'b0}}};
    sq_next.axy  = s5.axy;
    sq_next.bnum = s5.bnum;
    sq_next.bden = s5.bden;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_front  <= '0;
      v_sq[0]  <= 1'b0;
    end else if (en) begin
      v_front  <= {v_front[3:0], in_valid};
      v_sq[0]  <= v_front[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1    <= s1_next;
      s2    <= s2_next;
      s3    <= s3_next;
      s4    <= s4_next;
      s5    <= s5_next;
      sq[0] <= sq_next;
    end
  end

  // root extraction: one result bit a stage
  for (genvar i = 1; i <= RT; i++) begin : g_sqrt
    logic [RT+3:0] cur;
    logic [RT+3:0] trial;
    logic          fit;
    assign cur   = {sq[i-1].rem[RT+1:0], sq[i-1].rad[2*RT-1 -: 2]};
    assign trial = (RT + 4)'({sq[i-1].root, 2'b01});
    assign fit   = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_sq[i] <= 1'b0;
      end else if (en) begin
        v_sq[i] <= v_sq[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq[i].kind <= sq[i-1].kind;
        sq[i].rem  <= fit ? cur - trial : cur;
        sq[i].root <= {sq[i-1].root[RT-2:0], fit};
        sq[i].rad  <= {sq[i-1].rad[2*RT-3:0], 2'b00};
        sq[i].axy  <= sq[i-1].axy;
        sq[i].bnum <= sq[i-1].bnum;
        sq[i].bden <= sq[i-1].bden;
      end
    end
  end

  // feather numerator and denominator
  always_comb begin
    logic [PW-1:0] p;
    p            = {sq[RT].axy, {GD{1'b0}}};
    dv_next.kind = sq[RT].kind;
    dv_next.q    = '0;
    dv_next.rem  = RW'(sq[RT].bnum) << ALPHA_FRAC_BITS;
    dv_next.den  = DW'(sq[RT].bden);
    case (sq[RT].kind)
      ftsa_pkg::KIND_ELL: begin
        if (sq[RT].root >= p) begin
          dv_next.kind = ftsa_pkg::KIND_ZERO;
        end else begin
          dv_next.kind = ftsa_pkg::KIND_DIV;
        end
        dv_next.rem = (RW'(p - sq[RT].root) * RW'(ftsa_pkg::FEATHER_NUM))
                      << ALPHA_FRAC_BITS;
        dv_next.den = {p, 1'b0};
      end
      ftsa_pkg::KIND_BAND: dv_next.kind = ftsa_pkg::KIND_DIV;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_dv[0] <= 1'b0;
    end else if (en) begin
      v_dv[0] <= v_sq[RT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0] <= dv_next;
    end
  end

  // restoring divider: one quotient bit a stage, most significant first
  for (genvar j = 1; j <= QB; j++) begin : g_div
    localparam int K = QB - j;
    logic [RW-1:0] trial;
    logic          fit;
    assign trial = RW'(dv[j-1].den) << K;
    assign fit   = dv[j-1].rem >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_dv[j] <= 1'b0;
      end else if (en) begin
        v_dv[j] <= v_dv[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[j].kind <= dv[j-1].kind;
        dv[j].den  <= dv[j-1].den;
        dv[j].rem  <= fit ? dv[j-1].rem - trial : dv[j-1].rem;
        dv[j].q    <= dv[j-1].q | (fit ? (QB'(1) << K) : '0);
      end
    end
  end

  always_comb begin
    case (dv[QB].kind)
      ftsa_pkg::KIND_ONE: alpha_next = ONE;
      ftsa_pkg::KIND_DIV: alpha_next = (dv[QB].q > ONE) ? ONE : dv[QB].q;
      default:            alpha_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_dv[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      alpha <= alpha_next;
      dark  <= alpha_next >= HALF;
    end
  end

`include "fingertip_shape_alpha_pixel_macros.svh"

  `FTSA_ASSERT_IMPLY(a_alpha_range, out_valid, alpha <= ONE, "alpha above one")
  `FTSA_ASSERT_IMPLY(a_dark_match, out_valid, dark == (alpha >= HALF), "dark flag mismatch")
  `FTSA_ASSERT_IMPLY(a_div_den, v_dv[0] && dv[0].kind == ftsa_pkg::KIND_DIV, dv[0].den != '0, "zero divisor")
  `FTSA_ASSERT_NEXT(a_hold, !en, $stable({v_front, v_sq, v_dv, out_valid}), "pipeline moved while held")

endmodule

`default_nettype wire
